// ----- rtl/core/mbrt_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrt_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus RTU read master.
// ----------------------------------------------------------------------------
package mbrt_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REG = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
    localparam logic [15:0] FIRST_REG_RESET = 16'h0000;

    // Frame constants
    localparam logic [7:0]  FN_READ      = 8'h03;
    localparam logic [7:0]  FN_EXC_MASK  = 8'h80;
    localparam logic [15:0] READ_QTY     = 16'h0002;
    localparam logic [7:0]  BYTE_COUNT   = 8'h04;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Response byte positions
    localparam logic [3:0] RX_ADDR      = 4'd0;
    localparam logic [3:0] RX_FUNC      = 4'd1;
    localparam logic [3:0] RX_COUNT     = 4'd2;
    localparam logic [3:0] RX_W0_HI     = 4'd3;
    localparam logic [3:0] RX_W0_LO     = 4'd4;
    localparam logic [3:0] RX_W1_HI     = 4'd5;
    localparam logic [3:0] RX_W1_LO     = 4'd6;
    localparam logic [3:0] RX_CRC_LO    = 4'd7;

    // Request byte positions
    localparam logic [2:0] TX_ADDR      = 3'd0;
    localparam logic [2:0] TX_FUNC      = 3'd1;
    localparam logic [2:0] TX_REG_HI    = 3'd2;
    localparam logic [2:0] TX_REG_LO    = 3'd3;
    localparam logic [2:0] TX_CNT_HI    = 3'd4;
    localparam logic [2:0] TX_CNT_LO    = 3'd5;
    localparam logic [2:0] TX_CRC_LO    = 3'd6;
    localparam logic [2:0] TX_CRC_HI    = 3'd7;

    // Completion status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_ADDR    = 3'd3;
    localparam logic [2:0] ST_EXC     = 3'd4;
    localparam logic [2:0] ST_FUNC    = 3'd5;
    localparam logic [2:0] ST_COUNT   = 3'd6;

    typedef enum logic [0:0] {
        PH_IDLE = 1'b0,
        PH_WAIT = 1'b1
    } phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] slave_address;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               last;
        logic               done_res;
        logic [2:0]         status;
        logic [7:0]         exception_code;
        logic [15:0]        moisture_tenths;
        logic signed [15:0] temperature_tenths;
    } result_t;

    // Work handed from the transaction engine to the output sequencer
    typedef struct packed {
        logic        start;
        logic        done;
        logic [7:0]  address;
        logic [15:0] first_reg;
        logic [2:0]  status;
        logic [7:0]  exc_code;
        logic [15:0] moist;
        logic [15:0] temp;
    } event_t;

    // One byte of CRC-16, reflected polynomial, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/mbrt_engine.sv -----
// ----------------------------------------------------------------------------
// mbrt_engine
// Transaction state: latches the target on start, collects and checks the
// response, counts the timeout, and raises one event per item with a result.
// ----------------------------------------------------------------------------
module mbrt_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            accept,
    input  mbrt_pkg::item_t                 item,
    output mbrt_pkg::event_t                ev
);

    mbrt_pkg::phase_t phase_reg, phase_next;
    logic [15:0] timeout_reg;
    logic [15:0] first_reg_reg;
    logic [7:0]  target_reg, target_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  hdr_reg [3];
    logic [15:0] word0_reg, word1_reg;
    logic [7:0]  crc_lo_reg;
    logic [15:0] rx_crc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= mbrt_pkg::TIMEOUT_RESET;
            first_reg_reg <= mbrt_pkg::FIRST_REG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrt_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                mbrt_pkg::CFG_FIRST_REG: first_reg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rx_crc = {item.rx_byte, crc_lo_reg};

    // Next state and event
    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        ticks_next  = ticks_reg;
        ev          = '0;
        ev.address   = item.slave_address;
        ev.first_reg = first_reg_reg;

        if (accept)
        begin
            if (item.func == mbrt_pkg::FUNC_START)
            begin
                ev.start    = 1'b1;
                target_next = item.slave_address;
                phase_next  = mbrt_pkg::PH_WAIT;
                count_next  = '0;
                crc_next    = mbrt_pkg::CRC_INIT;
                ticks_next  = timeout_reg;
            end
            else if (phase_reg == mbrt_pkg::PH_WAIT && item.func == mbrt_pkg::FUNC_TICK)
            begin
                if (ticks_reg <= 16'd1)
                begin
                    ticks_next = '0;
                    phase_next = mbrt_pkg::PH_IDLE;
                    count_next = '0;
                    ev.done    = 1'b1;
                    ev.status  = mbrt_pkg::ST_TIMEOUT;
                end
                else
                begin
                    ticks_next = ticks_reg - 16'd1;
                end
            end
            else if (phase_reg == mbrt_pkg::PH_WAIT && item.func == mbrt_pkg::FUNC_BYTE)
            begin
                if (count_reg < mbrt_pkg::RX_CRC_LO)
                    crc_next = mbrt_pkg::crc_byte(crc_reg, item.rx_byte);
                if (count_reg > mbrt_pkg::RX_CRC_LO)
                begin
                    // Ninth byte: check in order crc, address, exception, function, count
                    phase_next = mbrt_pkg::PH_IDLE;
                    count_next = '0;
                    ev.done    = 1'b1;
                    priority if (rx_crc != crc_reg)
                        ev.status = mbrt_pkg::ST_CRC;
                    else if (hdr_reg[0] != target_reg)
                        ev.status = mbrt_pkg::ST_ADDR;
                    else if (hdr_reg[1] != mbrt_pkg::FN_READ && (hdr_reg[1] & mbrt_pkg::FN_EXC_MASK) != 8'h00)
                    begin
                        ev.status   = mbrt_pkg::ST_EXC;
                        ev.exc_code = hdr_reg[2];
                    end
                    else if (hdr_reg[1] != mbrt_pkg::FN_READ)
                        ev.status = mbrt_pkg::ST_FUNC;
                    else if (hdr_reg[2] != mbrt_pkg::BYTE_COUNT)
                        ev.status = mbrt_pkg::ST_COUNT;
                    else
                    begin
                        ev.status = mbrt_pkg::ST_OK;
                        ev.moist  = word0_reg;
                        ev.temp   = word1_reg;
                    end
                end
                else
                begin
                    count_next = count_reg + 4'd1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mbrt_pkg::PH_IDLE;
            target_reg <= '0;
            count_reg  <= '0;
            crc_reg    <= mbrt_pkg::CRC_INIT;
            ticks_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            ticks_reg  <= ticks_next;
        end
    end

    // Capture response fields
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == mbrt_pkg::PH_WAIT && item.func == mbrt_pkg::FUNC_BYTE)
        begin
            unique case (count_reg)
                mbrt_pkg::RX_ADDR:   hdr_reg[0]       <= item.rx_byte;
                mbrt_pkg::RX_FUNC:   hdr_reg[1]       <= item.rx_byte;
                mbrt_pkg::RX_COUNT:  hdr_reg[2]       <= item.rx_byte;
                mbrt_pkg::RX_W0_HI:  word0_reg[15:8]  <= item.rx_byte;
                mbrt_pkg::RX_W0_LO:  word0_reg[7:0]   <= item.rx_byte;
                mbrt_pkg::RX_W1_HI:  word1_reg[15:8]  <= item.rx_byte;
                mbrt_pkg::RX_W1_LO:  word1_reg[7:0]   <= item.rx_byte;
                mbrt_pkg::RX_CRC_LO: crc_lo_reg       <= item.rx_byte;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/mbrt_tx_seq.sv -----
// ----------------------------------------------------------------------------
// mbrt_tx_seq
// Result register: serialises the eight request bytes with a running CRC, or
// holds one completion result, and tells the item side when it can take more.
// ----------------------------------------------------------------------------
module mbrt_tx_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mbrt_pkg::event_t  ev,
    output logic              free,
    output logic              result_valid,
    input  logic              result_stall,
    output mbrt_pkg::result_t result
);

    logic        busy_reg;
    logic        frame_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [7:0]  addr_reg;
    logic [15:0] first_reg_reg;
    logic [2:0]  status_reg;
    logic [7:0]  exc_reg;
    logic [15:0] moist_reg;
    logic [15:0] temp_reg;
    logic [7:0]  tx_byte;
    logic        take;
    logic        final_res;

    // Pick the request byte for the current position
    always_comb
    begin
        unique case (idx_reg)
            mbrt_pkg::TX_ADDR:   tx_byte = addr_reg;
            mbrt_pkg::TX_FUNC:   tx_byte = mbrt_pkg::FN_READ;
            mbrt_pkg::TX_REG_HI: tx_byte = first_reg_reg[15:8];
            mbrt_pkg::TX_REG_LO: tx_byte = first_reg_reg[7:0];
            mbrt_pkg::TX_CNT_HI: tx_byte = mbrt_pkg::READ_QTY[15:8];
            mbrt_pkg::TX_CNT_LO: tx_byte = mbrt_pkg::READ_QTY[7:0];
            mbrt_pkg::TX_CRC_LO: tx_byte = crc_reg[7:0];
            mbrt_pkg::TX_CRC_HI: tx_byte = crc_reg[15:8];
            default:             tx_byte = '0;
        endcase
    end

    assign take      = busy_reg && !result_stall;
    assign final_res = !frame_reg || idx_reg == mbrt_pkg::TX_CRC_HI;
    assign free      = !busy_reg || (take && final_res);

    // Drive the result fields
    always_comb
    begin
        result = '0;
        if (frame_reg)
        begin
            result.tx_valid = 1'b1;
            result.tx_byte  = tx_byte;
            result.last     = idx_reg == mbrt_pkg::TX_CRC_HI;
        end
        else
        begin
            result.done_res           = 1'b1;
            result.status             = status_reg;
            result.exception_code     = exc_reg;
            result.moisture_tenths    = moist_reg;
            result.temperature_tenths = temp_reg;
        end
    end

    assign result_valid = busy_reg;

    // Control: load on a new event, advance on each request taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            frame_reg <= 1'b0;
            idx_reg   <= '0;
            crc_reg   <= mbrt_pkg::CRC_INIT;
        end
        else if (accept && (ev.start || ev.done))
        begin
            busy_reg  <= 1'b1;
            frame_reg <= ev.start;
            idx_reg   <= '0;
            crc_reg   <= mbrt_pkg::CRC_INIT;
        end
        else if (take)
        begin
            if (final_res)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
            if (frame_reg && idx_reg < mbrt_pkg::TX_CRC_LO)
                crc_reg <= mbrt_pkg::crc_byte(crc_reg, tx_byte);
        end
    end

    // Payload: hold event contents
    always_ff @(posedge clk)
    begin
        if (accept && (ev.start || ev.done))
        begin
            addr_reg      <= ev.address;
            first_reg_reg <= ev.first_reg;
            status_reg    <= ev.status;
            exc_reg       <= ev.exc_code;
            moist_reg     <= ev.moist;
            temp_reg      <= ev.temp;
        end
    end

endmodule

// ----- rtl/core/modbus_rtu_read_transaction.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_read_transaction
// Modbus RTU master for one read of two holding registers.
// ----------------------------------------------------------------------------
// Items (start, received byte, timer tick) are taken one per clock when the
// item channel does not stall; their effect on the transaction is settled in
// that cycle, and a result, when there is one, appears in the result register
// from the next cycle. A start item yields the eight request bytes through
// that single result register, one per transfer, with the request CRC built
// a byte at a time as they leave; the item channel stalls until the last of
// them is being taken, so a start costs eight result transfers, and a
// completion result one transfer. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module modbus_rtu_read_transaction (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  mbrt_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output mbrt_pkg::result_t               result
);

    logic             free;
    logic             accept;
    mbrt_pkg::event_t ev;

    assign item_stall = !free;
    assign accept     = item_valid && free;

    mbrt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .ev        (ev)
    );

    mbrt_tx_seq u_tx_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .ev           (ev),
        .free         (free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
